/* rtl/edf_pkg.sv */
// Package with shared types, constants and codes of the EDF task scheduler.
package edf_pkg;

  localparam int unsigned ListDepth = 32;
  localparam int unsigned IdxW = $clog2(ListDepth);
  localparam int unsigned CntW = $clog2(ListDepth + 1);
  localparam int unsigned IdW = 16;
  localparam int unsigned TimeW = 31;
  localparam int unsigned EntryW = IdW + TimeW;

  typedef enum logic [2:0] {
    OpTimer   = 3'd0,
    OpArrival = 3'd1,
    OpFinish  = 3'd2,
    OpIoReq   = 3'd3,
    OpIoEnd   = 3'd4,
    OpDecide  = 3'd5
  } opcode_e;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [TimeW-1:0] event_time;
    logic [IdW-1:0]   task_id;
    logic [TimeW-1:0] task_deadline;
    logic [IdW-1:0]   running_cpu;
    logic [IdW-1:0]   running_io;
  } req_t;

  typedef struct packed {
    logic [IdW-1:0] cpu_pick;
    logic [IdW-1:0] io_pick;
    logic           overflowed;
  } rsp_t;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] deadline;
  } entry_t;

endpackage

/* rtl/edf_if.sv */
// Valid/ready channel interface for scheduler request and response beats.
interface edf_req_if;
  logic          valid;
  logic          ready;
  edf_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface edf_rsp_if;
  logic          valid;
  logic          ready;
  edf_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/edf_task_scheduler.sv */
// Top level of the EDF task scheduler with CPU and IO task lists.
//   channel  dir  beat content
//   req      in   opcode, time, id, deadline, running tasks
//   rsp      out  cpu_pick, io_pick, overflowed (decide only)
// One request is handled at a time; the block is not ready while it works.
// Each list walk reads its list RAM one entry at a time. An IO request or IO end
// inserts into one list and then removes from the other; a timer only sets the
// current time and touches neither list.
// Reset empties both lists and sets the current time to minus one.
// A waiting response holds the next request off until it is taken.
module edf_task_scheduler (
  input logic      clk_i,
  input logic      rst_ni,
  edf_req_if.sink  req_i,
  edf_rsp_if.source rsp_o
);
  typedef enum logic [3:0] {
    SIdle  = 4'b0001,
    SFirst = 4'b0010,
    SNext  = 4'b0100,
    SOut   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  edf_pkg::req_t req_q;
  logic [31:0] now_q, now_d;
  logic ovf_q, ovf_d, rsp_valid_q, rsp_valid_d;
  edf_pkg::rsp_t rsp_q, rsp_d;
  logic c_ins, c_rem, c_pick, c_busy, c_full, c_empty;
  logic i_ins, i_rem, i_pick, i_busy, i_full, i_empty;
  logic [edf_pkg::IdW-1:0] c_out, i_out;
  logic acc, io_idle;

  assign acc = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == SIdle) && !rsp_valid_q;
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;
  assign io_idle = (req_q.running_io == '0);

  edf_list u_cpu (
    .clk_i, .rst_ni, .ins_i(c_ins), .rem_i(c_rem), .pick_i(c_pick),
    .id_i(req_q.task_id), .dl_i(req_q.task_deadline), .now_i(now_q),
    .busy_o(c_busy), .full_o(c_full), .empty_o(c_empty), .pick_o(c_out)
  );

  edf_list u_io (
    .clk_i, .rst_ni, .ins_i(i_ins), .rem_i(i_rem), .pick_i(i_pick),
    .id_i(req_q.task_id), .dl_i(req_q.task_deadline), .now_i(now_q),
    .busy_o(i_busy), .full_o(i_full), .empty_o(i_empty), .pick_o(i_out)
  );

  always_comb begin
    state_d = state_q;
    now_d = now_q;
    ovf_d = ovf_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_d = rsp_q;
    c_ins = 1'b0; c_rem = 1'b0; c_pick = 1'b0;
    i_ins = 1'b0; i_rem = 1'b0; i_pick = 1'b0;
    unique case (state_q)
      SIdle: if (acc) state_d = SFirst;
      SFirst: begin
        state_d = SNext;
        unique case (req_q.opcode) inside
          edf_pkg::OpTimer: begin
            now_d = {1'b0, req_q.event_time};
            state_d = SIdle;
          end
          edf_pkg::OpArrival, edf_pkg::OpIoEnd: begin
            if (c_full) ovf_d = 1'b1;
            else c_ins = 1'b1;
          end
          edf_pkg::OpFinish: c_rem = 1'b1;
          edf_pkg::OpIoReq: begin
            if (i_full) ovf_d = 1'b1;
            else i_ins = 1'b1;
          end
          edf_pkg::OpDecide: begin
            c_pick = !c_empty;
            i_pick = io_idle && !i_empty;
          end
          default: state_d = SIdle;
        endcase
      end
      SNext: begin
        if (!c_busy && !i_busy) begin
          state_d = SOut;
          unique case (req_q.opcode)
            edf_pkg::OpIoReq: c_rem = 1'b1;
            edf_pkg::OpIoEnd: i_rem = 1'b1;
            default: ;
          endcase
        end
      end
      SOut: begin
        if (!c_busy && !i_busy) begin
          state_d = SIdle;
          if (req_q.opcode == edf_pkg::OpDecide) begin
            rsp_valid_d = 1'b1;
            rsp_d.cpu_pick = c_empty ? req_q.running_cpu : c_out;
            rsp_d.io_pick = (io_idle && !i_empty) ? i_out : req_q.running_io;
            rsp_d.overflowed = ovf_q;
          end
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      now_q <= '1;
      ovf_q <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      now_q <= now_d;
      ovf_q <= ovf_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) req_q <= req_i.data;
    rsp_q <= rsp_d;
  end
endmodule

/* rtl/edf_ram.sv */
// Generic single-port RAM with a registered read.
module edf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

/* rtl/edf_list.sv */
// One deadline-ordered task list: RAM, count and a sequencer for insert, remove and pick.
module edf_list (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        ins_i,
  input  logic                        rem_i,
  input  logic                        pick_i,
  input  logic [edf_pkg::IdW-1:0]     id_i,
  input  logic [edf_pkg::TimeW-1:0]   dl_i,
  input  logic [31:0]                 now_i,
  output logic                        busy_o,
  output logic                        full_o,
  output logic                        empty_o,
  output logic [edf_pkg::IdW-1:0]     pick_o
);
  typedef enum logic [6:0] {
    SIdle    = 7'b0000001,
    SInsRd   = 7'b0000010,
    SInsCmp  = 7'b0000100,
    SInsWr   = 7'b0001000,
    SRemRd   = 7'b0010000,
    SRemCmp  = 7'b0100000,
    SPickCmp = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [edf_pkg::CntW-1:0] cnt_q, cnt_d, ptr_q, ptr_d;
  edf_pkg::entry_t carry_q, carry_d, rdata, wdata;
  logic [edf_pkg::IdW-1:0] pick_q, pick_d, first_q, first_d;
  logic found_q, found_d, we;
  logic [edf_pkg::IdxW-1:0] addr;

  edf_ram #(.Width(edf_pkg::EntryW), .Depth(edf_pkg::ListDepth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  assign busy_o  = (state_q != SIdle);
  assign full_o  = (cnt_q == edf_pkg::CntW'(edf_pkg::ListDepth));
  assign empty_o = (cnt_q == '0);
  assign pick_o  = pick_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ptr_d   = ptr_q;
    carry_d = carry_q;
    pick_d  = pick_q;
    first_d = first_q;
    found_d = found_q;
    we      = 1'b0;
    addr    = ptr_q[edf_pkg::IdxW-1:0];
    wdata   = carry_q;
    unique case (state_q)
      SIdle: begin
        ptr_d = '0;
        addr  = '0;
        found_d = 1'b0;
        if (ins_i) begin
          carry_d = '{id: id_i, deadline: dl_i};
          state_d = SInsRd;
        end else if (rem_i) begin
          carry_d.id = id_i;
          state_d = SRemRd;
        end else if (pick_i) begin
          state_d = SPickCmp;
        end
      end
      SInsRd: begin
        if (ptr_q == cnt_q) begin
          state_d = SInsWr;
        end else begin
          state_d = SInsCmp;
        end
      end
      SInsCmp: begin
        // Once the slot is found, every later entry moves up by one.
        ptr_d = ptr_q + 1'b1;
        addr  = ptr_d[edf_pkg::IdxW-1:0];
        if (found_q || rdata.deadline > carry_q.deadline) begin
          we      = 1'b1;
          addr    = ptr_q[edf_pkg::IdxW-1:0];
          carry_d = rdata;
          found_d = 1'b1;
        end
        state_d = SInsRd;
      end
      SInsWr: begin
        we      = 1'b1;
        cnt_d   = cnt_q + 1'b1;
        state_d = SIdle;
      end
      SRemRd: begin
        if (ptr_q == cnt_q) begin
          if (found_q) begin
            cnt_d = cnt_q - 1'b1;
          end
          state_d = SIdle;
        end else begin
          state_d = SRemCmp;
        end
      end
      SRemCmp: begin
        // After a match, each entry is copied one place down.
        if (found_q) begin
          we    = 1'b1;
          addr  = ptr_q[edf_pkg::IdxW-1:0] - 1'b1;
          wdata = rdata;
        end else if (rdata.id == carry_q.id) begin
          found_d = 1'b1;
        end
        ptr_d = ptr_q + 1'b1;
        state_d = SRemRd;
      end
      SPickCmp: begin
        if (ptr_q != '0 && ptr_q == cnt_q) begin
          pick_d  = first_q;
          state_d = SIdle;
        end else if (ptr_q != '0 && $signed({1'b0, rdata.deadline}) > $signed(now_i)) begin
          pick_d  = rdata.id;
          state_d = SIdle;
        end else begin
          if (ptr_q == '0) begin
            first_d = rdata.id;
            pick_d  = rdata.id;
            ptr_d   = ptr_q + 1'b1;
            if ($signed({1'b0, rdata.deadline}) > $signed(now_i) ||
                cnt_q == edf_pkg::CntW'(1)) begin
              state_d = SIdle;
            end
          end else begin
            ptr_d = ptr_q + 1'b1;
          end
          addr = ptr_d[edf_pkg::IdxW-1:0];
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q   <= '0;
      ptr_q   <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ptr_q   <= ptr_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
    pick_q  <= pick_d;
    first_q <= first_d;
  end
endmodule

/* rtl/edf_checker.sv */
// Port-level assertions for the EDF task scheduler, bound to the top level.
module edf_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input edf_pkg::rsp_t rsp_data_i
);
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i) else $error("ready after accept");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_data_i))
    else $error("rsp dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !req_ready_i) else $error("ready with pending rsp");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && $past(rsp_valid_i) && $past(rsp_data_i.overflowed)
      |-> rsp_data_i.overflowed)
    else $error("flag cleared");
endmodule

bind edf_task_scheduler edf_checker u_edf_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .req_valid_i(req_i.valid), .req_ready_i(req_i.ready),
  .rsp_valid_i(rsp_o.valid), .rsp_ready_i(rsp_o.ready), .rsp_data_i(rsp_o.data)
);

/* test/tb_edf_task_scheduler.sv */
// Self-checking testbench for the EDF task scheduler with a scoreboard class and random beats.
`timescale 1ns / 1ps

module tb_edf_task_scheduler;

  localparam int unsigned StallLimit = 4000;
  localparam int unsigned NumPerPhase = 415;
  localparam longint unsigned MaxTime = 64'h7FFF_FFFF;

  class sched_scoreboard;
    bit [edf_pkg::IdW-1:0]   ids[2][edf_pkg::ListDepth];
    bit [edf_pkg::TimeW-1:0] dls[2][edf_pkg::ListDepth];
    int                      cnt[2];
    longint                  now;
    bit                      ovf;
    edf_pkg::rsp_t           due[$];
    int                      errors;

    function new();
      cnt[0] = 0;
      cnt[1] = 0;
      now = -1;
      ovf = 1'b0;
      errors = 0;
    endfunction

    function void list_insert(int l, bit [edf_pkg::IdW-1:0] id,
                              bit [edf_pkg::TimeW-1:0] dl);
      int pos;
      if (cnt[l] >= edf_pkg::ListDepth) begin
        ovf = 1'b1;
        return;
      end
      pos = 0;
      while (pos < cnt[l] && dls[l][pos] <= dl) pos++;
      for (int k = cnt[l]; k > pos; k--) begin
        ids[l][k] = ids[l][k-1];
        dls[l][k] = dls[l][k-1];
      end
      ids[l][pos] = id;
      dls[l][pos] = dl;
      cnt[l]++;
    endfunction

    function void list_remove(int l, bit [edf_pkg::IdW-1:0] id);
      for (int pos = 0; pos < cnt[l]; pos++) begin
        if (ids[l][pos] == id) begin
          for (int k = pos; k + 1 < cnt[l]; k++) begin
            ids[l][k] = ids[l][k+1];
            dls[l][k] = dls[l][k+1];
          end
          cnt[l]--;
          return;
        end
      end
    endfunction

    function bit [edf_pkg::IdW-1:0] earliest_live(int l);
      for (int pos = 0; pos < cnt[l]; pos++) begin
        if (longint'(dls[l][pos]) > now) return ids[l][pos];
      end
      return ids[l][0];
    endfunction

    function void note_request(edf_pkg::req_t r);
      edf_pkg::rsp_t e;
      case (r.opcode)
        edf_pkg::OpTimer:   now = longint'(r.event_time);
        edf_pkg::OpArrival: list_insert(0, r.task_id, r.task_deadline);
        edf_pkg::OpFinish:  list_remove(0, r.task_id);
        edf_pkg::OpIoReq: begin
          list_insert(1, r.task_id, r.task_deadline);
          list_remove(0, r.task_id);
        end
        edf_pkg::OpIoEnd: begin
          list_insert(0, r.task_id, r.task_deadline);
          list_remove(1, r.task_id);
        end
        edf_pkg::OpDecide: begin
          e.io_pick = r.running_io;
          if (r.running_io == '0 && cnt[1] != 0) e.io_pick = earliest_live(1);
          e.cpu_pick = r.running_cpu;
          if (cnt[0] != 0) e.cpu_pick = earliest_live(0);
          e.overflowed = ovf;
          due.push_back(e);
        end
        default: ;
      endcase
    endfunction

    function void check_pick(edf_pkg::rsp_t got);
      edf_pkg::rsp_t e;
      if (due.size() == 0) begin
        $display("%0t: response with none expected, got %h", $time, got);
        errors++;
        return;
      end
      e = due.pop_front();
      if (got.cpu_pick !== e.cpu_pick) begin
        $display("%0t: cpu_pick expected %h actual %h", $time, e.cpu_pick, got.cpu_pick);
        errors++;
      end
      if (got.io_pick !== e.io_pick) begin
        $display("%0t: io_pick expected %h actual %h", $time, e.io_pick, got.io_pick);
        errors++;
      end
      if (got.overflowed !== e.overflowed) begin
        $display("%0t: overflowed expected %b actual %b", $time, e.overflowed,
                 got.overflowed);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int   idle_pct;
  int   stall_pct;
  int   quiet_cycles;
  sched_scoreboard sb;

  edf_req_if req_ch ();
  edf_rsp_if rsp_ch ();

  edf_task_scheduler dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch.sink),
    .rsp_o (rsp_ch.source)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(negedge clk_i) begin
    rsp_ch.ready = ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) sb.check_pick(rsp_ch.data);
    if (rst_ni && !(rsp_ch.valid && rsp_ch.ready) && !(req_ch.valid && req_ch.ready)) begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("tb_edf_task_scheduler: errors");
        $finish;
      end
    end else begin
      quiet_cycles = 0;
    end
  end

  function automatic bit [edf_pkg::TimeW-1:0] near_time(longint base);
    longint t;
    t = base + longint'($urandom_range(200)) - 100;
    if (t < 0) t = 0;
    if (t > longint'(MaxTime)) t = longint'(MaxTime);
    return t[edf_pkg::TimeW-1:0];
  endfunction

  function automatic edf_pkg::req_t blank_req(edf_pkg::opcode_e op);
    edf_pkg::req_t r;
    r.opcode = op;
    r.event_time = edf_pkg::TimeW'($urandom());
    r.task_id = edf_pkg::IdW'($urandom());
    r.task_deadline = edf_pkg::TimeW'($urandom());
    r.running_cpu = edf_pkg::IdW'($urandom());
    r.running_io = ($urandom_range(1) != 0) ? '0 : edf_pkg::IdW'($urandom());
    return r;
  endfunction

  function automatic bit [edf_pkg::IdW-1:0] pick_id(int l);
    if (sb.cnt[l] > 0 && $urandom_range(99) < 80)
      return sb.ids[l][$urandom_range(sb.cnt[l] - 1)];
    if ($urandom_range(9) == 0) return edf_pkg::IdW'($urandom());
    return edf_pkg::IdW'($urandom_range(1, 40));
  endfunction

  function automatic edf_pkg::req_t random_req();
    edf_pkg::req_t r;
    int   w;
    longint base;
    w = $urandom_range(99);
    base = (sb.now < 0) ? 1000 : sb.now;
    if (w < 2) begin
      r = blank_req(edf_pkg::OpDecide);
      r.opcode = 3'($urandom_range(6, 7));
    end else if (w < 10) begin
      r = blank_req(edf_pkg::OpTimer);
      if ($urandom_range(4) != 0) r.event_time = near_time(base + 20);
    end else if (w < 35) begin
      r = blank_req((sb.cnt[0] < 28) ? edf_pkg::OpArrival : edf_pkg::OpFinish);
      r.task_id = pick_id(sb.cnt[0] < 28 ? 1 : 0);
      if (r.opcode == edf_pkg::OpArrival && $urandom_range(2) == 0)
        r.task_id = edf_pkg::IdW'($urandom_range(1, 40));
    end else if (w < 50) begin
      r = blank_req(edf_pkg::OpFinish);
      r.task_id = pick_id(0);
    end else if (w < 62) begin
      r = blank_req(sb.cnt[1] < 28 ? edf_pkg::OpIoReq : edf_pkg::OpIoEnd);
      r.task_id = pick_id(r.opcode == edf_pkg::OpIoReq ? 0 : 1);
    end else if (w < 75) begin
      r = blank_req(edf_pkg::OpIoEnd);
      r.task_id = pick_id(1);
    end else begin
      r = blank_req(edf_pkg::OpDecide);
    end
    if (r.opcode inside {edf_pkg::OpArrival, edf_pkg::OpIoReq, edf_pkg::OpIoEnd} &&
        $urandom_range(9) != 0) begin
      r.task_deadline = near_time(base);
    end
    return r;
  endfunction

  task automatic send_beat(edf_pkg::req_t r);
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid = 1'b1;
    req_ch.data = r;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    sb.note_request(r);
    @(negedge clk_i);
  endtask

  task automatic send_op(edf_pkg::opcode_e op, bit [edf_pkg::IdW-1:0] id,
                         bit [edf_pkg::TimeW-1:0] dl, bit [edf_pkg::TimeW-1:0] t,
                         bit [edf_pkg::IdW-1:0] rcpu, bit [edf_pkg::IdW-1:0] rio);
    edf_pkg::req_t r;
    r.opcode = op;
    r.event_time = t;
    r.task_id = id;
    r.task_deadline = dl;
    r.running_cpu = rcpu;
    r.running_io = rio;
    send_beat(r);
  endtask

  task automatic drain();
    req_ch.valid = 1'b0;
    while (sb.due.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  initial begin
    edf_pkg::req_t r;
    sb = new();
    quiet_cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_op(edf_pkg::OpDecide, 16'h0, '0, '0, 16'hFFFF, 16'h0);
    send_op(edf_pkg::OpDecide, 16'h0, '0, '0, 16'h0, 16'hFFFF);
    send_op(edf_pkg::OpArrival, 16'hFFFF, 31'h7FFF_FFFF, '0, '0, '0);
    send_op(edf_pkg::OpArrival, 16'h0001, 31'd0, '0, '0, '0);
    send_op(edf_pkg::OpArrival, 16'h0002, 31'd50, '0, '0, '0);
    send_op(edf_pkg::OpArrival, 16'h0003, 31'd50, '0, '0, '0);
    send_op(edf_pkg::OpDecide, '0, '0, '0, 16'h1234, 16'h0);
    send_op(edf_pkg::OpTimer, '0, '0, 31'd50, '0, '0);
    send_op(edf_pkg::OpDecide, '0, '0, '0, 16'h1234, 16'h0);
    send_op(edf_pkg::OpFinish, 16'h0003, '0, '0, '0, '0);
    send_op(edf_pkg::OpFinish, 16'h7777, '0, '0, '0, '0);
    send_op(edf_pkg::OpIoReq, 16'h0002, 31'd60, '0, '0, '0);
    send_op(edf_pkg::OpIoReq, 16'h0005, 31'd10, '0, '0, '0);
    send_op(edf_pkg::OpDecide, '0, '0, '0, 16'h0, 16'h0);
    send_op(edf_pkg::OpDecide, '0, '0, '0, 16'h0, 16'h0009);
    send_op(edf_pkg::OpTimer, '0, '0, 31'h7FFF_FFFF, '0, '0);
    send_op(edf_pkg::OpDecide, '0, '0, '0, 16'hAAAA, 16'h0);
    send_op(edf_pkg::OpIoEnd, 16'h0002, 31'd5, '0, '0, '0);
    send_op(edf_pkg::OpIoEnd, 16'h4444, 31'd5, '0, '0, '0);
    r = blank_req(edf_pkg::OpDecide);
    r.opcode = 3'd6;
    send_beat(r);
    r.opcode = 3'd7;
    send_beat(r);
    send_op(edf_pkg::OpTimer, '0, '0, 31'd0, '0, '0);
    send_op(edf_pkg::OpDecide, '0, '0, '0, 16'h5555, 16'h0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 50; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 50; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      for (int i = 0; i < NumPerPhase; i++) begin
        if (ph == 3 && i == NumPerPhase / 2) begin
          idle_pct = 0;
          stall_pct = 0;
        end
        send_beat(random_req());
      end
      if (ph == 1) drain();
    end

    idle_pct = 0;
    stall_pct = 0;
    for (int i = 0; i <= edf_pkg::ListDepth; i++)
      send_op(edf_pkg::OpArrival, edf_pkg::IdW'(100 + i), 31'(i), '0, '0, '0);
    send_op(edf_pkg::OpDecide, '0, '0, '0, '0, '0);
    for (int i = 0; i <= edf_pkg::ListDepth; i++)
      send_op(edf_pkg::OpIoReq, edf_pkg::IdW'(200 + i), 31'(i), '0, '0, '0);
    send_op(edf_pkg::OpIoEnd, 16'd205, 31'd3, '0, '0, '0);
    send_op(edf_pkg::OpDecide, '0, '0, '0, '0, '0);

    drain();
    if (sb.errors == 0) begin
      $display("tb_edf_task_scheduler: clean");
    end else begin
      $display("tb_edf_task_scheduler: errors");
    end
    $finish;
  end

endmodule
